// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the ellipse rasterizer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define MER_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define MER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// widths, codes and helpers for the midpoint ellipse rasterizer
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS = 12;
    localparam int AXIS_BITS  = 10;
    localparam int GRID_BITS  = 7;

    localparam int OUT_BITS  = COORD_BITS + 2;
    localparam int OFF_BITS  = AXIS_BITS + 1;
    localparam int SQ_BITS   = 2 * AXIS_BITS;
    // widest operand is (2x+1)^2
    localparam int MUL_BITS  = 2 * OFF_BITS + 2;
    localparam int PROD_BITS = 2 * MUL_BITS;
    // decision value, four times the real midpoint value
    localparam int DEC_BITS  = 4 * AXIS_BITS + 8;
    localparam int DX_BITS   = OFF_BITS + GRID_BITS;
    localparam int SUM_BITS  = ((COORD_BITS > DX_BITS) ? COORD_BITS : DX_BITS) + 2;

    localparam int OUT_HI = 2 ** (OUT_BITS - 1) - 1;
    localparam int OUT_LO = -(2 ** (OUT_BITS - 1));

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } t_phase;

    // bookkeeping applied once the point set has been handed over
    typedef enum logic [1:0] {
        POST_START,
        POST_STEP_X,
        POST_STEP_Y
    } t_post;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_AB,
        ST_INIT_D,
        ST_R1_BX,
        ST_R1_AY,
        ST_R1_CMP,
        ST_R1_INC,
        ST_R1_DEC,
        ST_BR_Y2,
        ST_BR_BX,
        ST_BR_AY,
        ST_BR_AB,
        ST_BR_FIN,
        ST_R2_AY,
        ST_R2_SUB,
        ST_R2_BX,
        ST_EM_X,
        ST_EM_Y,
        ST_OUT
    } t_state;

    // clamp a coordinate to the signed output range
    function automatic logic signed [OUT_BITS-1:0] sat_coord(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        logic signed [OUT_BITS-1:0] res;
        hi = SUM_BITS'(OUT_HI);
        lo = SUM_BITS'(OUT_LO);
        if (v > hi) begin
            res = hi[OUT_BITS-1:0];
        end else if (v < lo) begin
            res = lo[OUT_BITS-1:0];
        end else begin
            res = v[OUT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/mer_in_if.sv =====
// ----------------------------------------------------------------------------
// mer_in_if
// request channel: start a new ellipse or advance one pixel
// ----------------------------------------------------------------------------
interface mer_in_if import mer_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_BITS-1:0]  semi_axis_x;
    logic [AXIS_BITS-1:0]  semi_axis_y;

    modport source (
        output valid, req_type, center_x, center_y, semi_axis_x, semi_axis_y,
        input  ready
    );

    modport sink (
        input  valid, req_type, center_x, center_y, semi_axis_x, semi_axis_y,
        output ready
    );

endinterface

// ===== sv/mer_out_if.sv =====
// ----------------------------------------------------------------------------
// mer_out_if
// point set channel: two x and two y values plus end flag
// ----------------------------------------------------------------------------
interface mer_out_if import mer_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] x_right;
    logic signed [OUT_BITS-1:0] x_left;
    logic signed [OUT_BITS-1:0] y_upper;
    logic signed [OUT_BITS-1:0] y_lower;
    logic                       is_last;

    modport source (
        output valid, x_right, x_left, y_upper, y_lower, is_last,
        input  ready
    );

    modport sink (
        input  valid, x_right, x_left, y_upper, y_lower, is_last,
        output ready
    );

endinterface

// ===== sv/midpoint_ellipse_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// midpoint ellipse walker, at most one symmetric point set per request word
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word contents
//  i_req     in   valid/ready    req_type, center_x/y, semi_axis_x/y
//  o_pix     out  valid/ready    x_right, x_left, y_upper, y_lower, is_last
//  i_cfg     in   write enable   grid_step (7 bits), no read-back
//
//  a word is taken in the idle state; a start, a region 1 step, a bridge
//  point and a region 2 step each run their own sequence of states, the
//  bridge being shorter when it closes the ellipse; a step with no ellipse
//  running is taken in the idle state and gives no point set.
//  every product of the decision update and of the grid scaling goes
//  through the single shared multiplier in turn.
//  i_req.ready is high only in the idle state; the point set sits in an
//  output register, so a new word is taken while o_pix stalls, and the
//  sequencer only waits in its final state if that register is still full.
//  reset is synchronous, active low; grid_step resets to one.
//
module midpoint_ellipse_rasterizer_core import mer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GRID_BITS-1:0] i_cfg_wdata,
    mer_in_if.sink               i_req,
    mer_out_if.source            o_pix
);

`include "assert_macros.svh"

    // control state
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_o_valid, n_o_valid;
    logic [GRID_BITS-1:0] r_grid;

    // working registers
    t_post r_post, n_post;
    logic  r_last, n_last;
    logic  r_inc, n_inc;
    logic [COORD_BITS-1:0] r_ctr_x, n_ctr_x;
    logic [COORD_BITS-1:0] r_ctr_y, n_ctr_y;
    logic [AXIS_BITS-1:0]  r_a, n_a;
    logic [AXIS_BITS-1:0]  r_b, n_b;
    logic [SQ_BITS-1:0]    r_a2, n_a2;
    logic [SQ_BITS-1:0]    r_b2, n_b2;
    logic [OFF_BITS-1:0]   r_off_x, n_off_x;
    logic [OFF_BITS-1:0]   r_off_y, n_off_y;
    logic [OFF_BITS:0]     r_xn, n_xn;
    logic [DEC_BITS-1:0]   r_dec, n_dec;
    logic [PROD_BITS-1:0]  r_tmp, n_tmp;
    logic [DX_BITS-1:0]    r_dx, n_dx;

    // output word register
    logic signed [OUT_BITS-1:0] r_o_xr, n_o_xr;
    logic signed [OUT_BITS-1:0] r_o_xl, n_o_xl;
    logic signed [OUT_BITS-1:0] r_o_yu, n_o_yu;
    logic signed [OUT_BITS-1:0] r_o_yl, n_o_yl;
    logic                       r_o_last, n_o_last;

    // shared multiplier
    logic [MUL_BITS-1:0]  mul_a;
    logic [MUL_BITS-1:0]  mul_b;
    logic [PROD_BITS-1:0] prod;

    logic                 out_free;
    logic [GRID_BITS-1:0] grid_eff;
    logic [OFF_BITS:0]    x2p1;
    logic [OFF_BITS-1:0]  off_y_m1;
    logic [OFF_BITS:0]    x_plus1;
    logic [OFF_BITS:0]    x_sel;
    logic                 dec_neg;
    logic                 dec_pos;
    logic signed [SUM_BITS-1:0] cx_s;
    logic signed [SUM_BITS-1:0] cy_s;
    logic signed [SUM_BITS-1:0] dx_s;
    logic signed [SUM_BITS-1:0] dy_s;

    mer_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (prod)
    );

    assign out_free  = !r_o_valid || o_pix.ready;
    // zero grid step from software means one pixel per cell
    assign grid_eff  = (r_grid == '0) ? GRID_BITS'(1) : r_grid;
    assign x2p1      = {r_off_x, 1'b1};
    assign off_y_m1  = r_off_y - OFF_BITS'(1);
    assign x_plus1   = {1'b0, r_off_x} + (OFF_BITS + 1)'(1);
    assign dec_neg   = r_dec[DEC_BITS-1];
    assign dec_pos   = !r_dec[DEC_BITS-1] && (r_dec != '0);

    // point set arithmetic, offsets already scaled by the grid step
    assign cx_s = signed'(SUM_BITS'(r_ctr_x));
    assign cy_s = signed'(SUM_BITS'(r_ctr_y));
    assign dx_s = signed'(SUM_BITS'(r_dx));
    assign dy_s = signed'(SUM_BITS'(prod[DX_BITS-1:0]));

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_pix.valid   = r_o_valid;
    assign o_pix.x_right = r_o_xr;
    assign o_pix.x_left  = r_o_xl;
    assign o_pix.y_upper = r_o_yu;
    assign o_pix.y_lower = r_o_yl;
    assign o_pix.is_last = r_o_last;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_o_valid = r_o_valid && !o_pix.ready;
        n_post    = r_post;
        n_last    = r_last;
        n_inc     = r_inc;
        n_ctr_x   = r_ctr_x;
        n_ctr_y   = r_ctr_y;
        n_a       = r_a;
        n_b       = r_b;
        n_a2      = r_a2;
        n_b2      = r_b2;
        n_off_x   = r_off_x;
        n_off_y   = r_off_y;
        n_xn      = r_xn;
        n_dec     = r_dec;
        n_tmp     = r_tmp;
        n_dx      = r_dx;
        n_o_xr    = r_o_xr;
        n_o_xl    = r_o_xl;
        n_o_yu    = r_o_yu;
        n_o_yl    = r_o_yl;
        n_o_last  = r_o_last;
        mul_a     = '0;
        mul_b     = '0;
        x_sel     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_START) begin
                        // a start drops whatever ellipse was running
                        n_ctr_x = i_req.center_x;
                        n_ctr_y = i_req.center_y;
                        n_a     = i_req.semi_axis_x;
                        n_b     = i_req.semi_axis_y;
                        n_off_x = '0;
                        n_off_y = OFF_BITS'(i_req.semi_axis_y);
                        n_state = ST_SQ_A;
                    end else begin
                        case (r_phase)
                            PH_R1:   n_state = ST_R1_BX;
                            PH_R2:   n_state = ST_R2_AY;
                            default: n_state = ST_IDLE;  // step while idle: no word
                        endcase
                    end
                end
            end

            // start: a^2, b^2, then d = 4b^2 - 4a^2 b + a^2
            ST_SQ_A: begin
                mul_a   = MUL_BITS'(r_a);
                mul_b   = MUL_BITS'(r_a);
                n_state = ST_SQ_B;
            end
            ST_SQ_B: begin
                n_a2    = prod[SQ_BITS-1:0];
                mul_a   = MUL_BITS'(r_b);
                mul_b   = MUL_BITS'(r_b);
                n_state = ST_AB;
            end
            ST_AB: begin
                n_b2    = prod[SQ_BITS-1:0];
                n_dec   = DEC_BITS'(r_a2) + (DEC_BITS'(prod[SQ_BITS-1:0]) << 2);
                mul_a   = MUL_BITS'(r_a2);
                mul_b   = MUL_BITS'(r_b);
                n_state = ST_INIT_D;
            end
            ST_INIT_D: begin
                n_dec   = r_dec - (DEC_BITS'(prod) << 2);
                n_post  = POST_START;
                n_last  = 1'b0;
                n_state = ST_EM_X;
            end

            // region 1: test b^2 x < a^2 y
            ST_R1_BX: begin
                mul_a   = MUL_BITS'(r_b2);
                mul_b   = MUL_BITS'(r_off_x);
                n_state = ST_R1_AY;
            end
            ST_R1_AY: begin
                n_tmp   = prod;
                mul_a   = MUL_BITS'(r_a2);
                mul_b   = MUL_BITS'(r_off_y);
                n_state = ST_R1_CMP;
            end
            ST_R1_CMP: begin
                n_last = 1'b0;
                if (r_tmp < prod) begin
                    mul_a   = MUL_BITS'(r_b2);
                    mul_b   = MUL_BITS'(x2p1);
                    n_post  = POST_STEP_X;
                    n_state = ST_R1_INC;
                end else if (r_off_y == '0) begin
                    // bridge point on the x axis closes the ellipse
                    n_last  = 1'b1;
                    n_post  = POST_STEP_Y;
                    n_state = ST_EM_X;
                end else begin
                    // bridge: d = b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2 b^2
                    mul_a   = MUL_BITS'(x2p1);
                    mul_b   = MUL_BITS'(x2p1);
                    n_post  = POST_STEP_Y;
                    n_state = ST_BR_Y2;
                end
            end
            ST_R1_INC: begin
                n_dec = r_dec + (DEC_BITS'(prod) << 2);
                if (dec_neg) begin
                    n_state = ST_EM_X;
                end else begin
                    n_off_y = off_y_m1;
                    mul_a   = MUL_BITS'(r_a2);
                    mul_b   = MUL_BITS'(off_y_m1);
                    n_state = ST_R1_DEC;
                end
            end
            ST_R1_DEC: begin
                n_dec   = r_dec - (DEC_BITS'(prod) << 3);
                n_state = ST_EM_X;
            end

            ST_BR_Y2: begin
                n_tmp   = prod;
                mul_a   = MUL_BITS'(off_y_m1);
                mul_b   = MUL_BITS'(off_y_m1);
                n_state = ST_BR_BX;
            end
            ST_BR_BX: begin
                n_tmp   = prod;
                mul_a   = MUL_BITS'(r_b2);
                mul_b   = r_tmp[MUL_BITS-1:0];
                n_state = ST_BR_AY;
            end
            ST_BR_AY: begin
                n_dec   = DEC_BITS'(prod);
                mul_a   = MUL_BITS'(r_a2);
                mul_b   = r_tmp[MUL_BITS-1:0];
                n_state = ST_BR_AB;
            end
            ST_BR_AB: begin
                n_dec   = r_dec + (DEC_BITS'(prod) << 2);
                mul_a   = MUL_BITS'(r_a2);
                mul_b   = MUL_BITS'(r_b2);
                n_state = ST_BR_FIN;
            end
            ST_BR_FIN: begin
                n_dec   = r_dec - (DEC_BITS'(prod) << 2);
                n_state = ST_EM_X;
            end

            // region 2: d += 4a^2(1-2y), plus 8b^2(x+1) when x moves
            ST_R2_AY: begin
                mul_a   = MUL_BITS'(r_a2);
                mul_b   = MUL_BITS'(r_off_y);
                n_dec   = r_dec + (DEC_BITS'(r_a2) << 2);
                n_inc   = !dec_pos;
                n_xn    = x_plus1;
                x_sel   = dec_pos ? {1'b0, r_off_x} : x_plus1;
                // x offset never passes the semi-axis in region 2
                n_off_x = (x_sel > (OFF_BITS + 1)'(r_a)) ? OFF_BITS'(r_a)
                                                         : x_sel[OFF_BITS-1:0];
                n_last  = (r_off_y == '0);
                n_post  = POST_STEP_Y;
                n_state = ST_R2_SUB;
            end
            ST_R2_SUB: begin
                n_dec = r_dec - (DEC_BITS'(prod) << 3);
                if (r_inc) begin
                    mul_a   = MUL_BITS'(r_b2);
                    mul_b   = MUL_BITS'(r_xn);
                    n_state = ST_R2_BX;
                end else begin
                    n_state = ST_EM_X;
                end
            end
            ST_R2_BX: begin
                n_dec   = r_dec + (DEC_BITS'(prod) << 3);
                n_state = ST_EM_X;
            end

            // scale offsets by the grid step
            ST_EM_X: begin
                mul_a   = MUL_BITS'(r_off_x);
                mul_b   = MUL_BITS'(grid_eff);
                n_state = ST_EM_Y;
            end
            ST_EM_Y: begin
                n_dx    = prod[DX_BITS-1:0];
                mul_a   = MUL_BITS'(r_off_y);
                mul_b   = MUL_BITS'(grid_eff);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // keep the y product alive while the output register is full
                mul_a = MUL_BITS'(r_off_y);
                mul_b = MUL_BITS'(grid_eff);
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_xr    = sat_coord(cx_s + dx_s);
                    n_o_xl    = sat_coord(cx_s - dx_s);
                    n_o_yu    = sat_coord(cy_s - dy_s);
                    n_o_yl    = sat_coord(cy_s + dy_s);
                    n_o_last  = r_last;
                    n_state   = ST_IDLE;
                    case (r_post)
                        POST_START: begin
                            n_off_x = OFF_BITS'(1);
                            n_phase = PH_R1;
                        end
                        POST_STEP_X: begin
                            n_off_x = r_off_x + OFF_BITS'(1);
                        end
                        POST_STEP_Y: begin
                            if (r_last) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_off_y = off_y_m1;
                                n_phase = PH_R2;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_IDLE;
            r_o_valid <= 1'b0;
            r_grid    <= GRID_BITS'(1);
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_grid <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_post   <= n_post;
        r_last   <= n_last;
        r_inc    <= n_inc;
        r_ctr_x  <= n_ctr_x;
        r_ctr_y  <= n_ctr_y;
        r_a      <= n_a;
        r_b      <= n_b;
        r_a2     <= n_a2;
        r_b2     <= n_b2;
        r_off_x  <= n_off_x;
        r_off_y  <= n_off_y;
        r_xn     <= n_xn;
        r_dec    <= n_dec;
        r_tmp    <= n_tmp;
        r_dx     <= n_dx;
        r_o_xr   <= n_o_xr;
        r_o_xl   <= n_o_xl;
        r_o_yu   <= n_o_yu;
        r_o_yl   <= n_o_yl;
        r_o_last <= n_o_last;
    end

    // a start word leaves the idle state, so the request channel is held off
    `MER_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n,
        i_req.valid && i_req.ready && (i_req.req_type == REQ_START), !i_req.ready,
        "start word did not hold off the request channel")

    // handing over the final point set ends the ellipse
    `MER_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n,
        (r_state == ST_OUT) && out_free && r_last, r_phase == PH_IDLE,
        "ellipse still running after its last point set")

    // region 1 only ever lowers the y offset from b
    `MER_ASSERT_SAME(a_r1_y_bound, i_clk, i_rst_n,
        r_phase == PH_R1, r_off_y <= OFF_BITS'(r_b),
        "y offset above semi-axis in region 1")

endmodule

// ===== sv/mer_mul.sv =====
// ----------------------------------------------------------------------------
// mer_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module mer_mul import mer_pkg::*; (
    input  logic                 i_clk,
    input  logic [MUL_BITS-1:0]  i_op_a,
    input  logic [MUL_BITS-1:0]  i_op_b,
    output logic [PROD_BITS-1:0] o_prod
);

    logic [PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_BITS'(i_op_a) * PROD_BITS'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== sim/mer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_checker
// watches the request and point set channels of the ellipse rasterizer,
// walks its own copy of the ellipse and compares every point set it sees
// ----------------------------------------------------------------------------
module mer_checker import mer_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GRID_BITS-1:0] i_cfg_wdata,
    mer_in_if                    i_req,
    mer_out_if                   i_pix,
    output int                   o_pending,
    output int                   o_fail_count
);

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x_right;
        logic signed [OUT_BITS-1:0] x_left;
        logic signed [OUT_BITS-1:0] y_upper;
        logic signed [OUT_BITS-1:0] y_lower;
        logic                       is_last;
    } t_point_set;

    t_point_set                 expected_points[$];

    logic [GRID_BITS-1:0]       grid_step;
    logic [OFF_BITS-1:0]        off_x;
    logic [OFF_BITS-1:0]        off_y;
    logic signed [DEC_BITS-1:0] decision;
    t_phase                     walk_phase;
    logic [COORD_BITS-1:0]      ctr_x;
    logic [COORD_BITS-1:0]      ctr_y;
    logic [AXIS_BITS-1:0]       axis_a;
    logic [AXIS_BITS-1:0]       axis_b;

    function automatic logic signed [OUT_BITS-1:0] clip_coord(input longint v);
        if (v > OUT_HI) begin
            return OUT_BITS'(OUT_HI);
        end
        if (v < OUT_LO) begin
            return OUT_BITS'(OUT_LO);
        end
        return OUT_BITS'(v);
    endfunction

    // four symmetric pixels of the current offsets, scaled by the grid step
    function automatic t_point_set scaled_points(input logic last);
        t_point_set p;
        longint     g;
        longint     dx;
        longint     dy;
        g  = (grid_step == '0) ? 64'd1 : longint'(grid_step);
        dx = longint'(off_x) * g;
        dy = longint'(off_y) * g;
        p.x_right = clip_coord(longint'(ctr_x) + dx);
        p.x_left  = clip_coord(longint'(ctr_x) - dx);
        p.y_upper = clip_coord(longint'(ctr_y) - dy);
        p.y_lower = clip_coord(longint'(ctr_y) + dy);
        p.is_last = last;
        return p;
    endfunction

    task automatic walk_request(
        input logic                  kind,
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [AXIS_BITS-1:0]  sa,
        input logic [AXIS_BITS-1:0]  sb
    );
        longint a;
        longint b;
        longint a2;
        longint b2;
        longint x;
        longint y;
        longint d;
        if (kind == REQ_START) begin
            ctr_x  = cx;
            ctr_y  = cy;
            axis_a = sa;
            axis_b = sb;
            a  = longint'(sa);
            b  = longint'(sb);
            a2 = a * a;
            b2 = b * b;
            off_x = '0;
            off_y = OFF_BITS'(b);
            expected_points.push_back(scaled_points(1'b0));
            off_x = OFF_BITS'(1);
            decision   = DEC_BITS'(4 * b2 - 4 * a2 * b + a2);
            walk_phase = PH_R1;
            return;
        end
        a  = longint'(axis_a);
        b  = longint'(axis_b);
        a2 = a * a;
        b2 = b * b;
        x  = longint'(off_x);
        y  = longint'(off_y);
        d  = longint'(decision);
        case (walk_phase)
            PH_R1: begin
                if (b2 * x < a2 * y) begin
                    if (d < 0) begin
                        d = d + 4 * b2 * (2 * x + 1);
                    end else begin
                        y = y - 1;
                        d = d + 4 * b2 * (2 * x + 1) - 8 * a2 * y;
                    end
                    decision = DEC_BITS'(d);
                    off_y    = OFF_BITS'(y);
                    expected_points.push_back(scaled_points(1'b0));
                    off_x = OFF_BITS'(x + 1);
                end else begin
                    // bridge point between the two regions
                    expected_points.push_back(scaled_points(y == 0));
                    if (y == 0) begin
                        walk_phase = PH_IDLE;
                    end else begin
                        y = y - 1;
                        off_y = OFF_BITS'(y);
                        d = b2 * (2 * x + 1) * (2 * x + 1) + 4 * a2 * y * y - 4 * a2 * b2;
                        decision   = DEC_BITS'(d);
                        walk_phase = PH_R2;
                    end
                end
            end
            PH_R2: begin
                if (d > 0) begin
                    d = d + 4 * a2 * (1 - 2 * y);
                end else begin
                    x = x + 1;
                    d = d + 4 * a2 * (1 - 2 * y) + 8 * b2 * x;
                end
                decision = DEC_BITS'(d);
                if (x > a) begin
                    x = a;
                end
                off_x = OFF_BITS'(x);
                expected_points.push_back(scaled_points(y == 0));
                if (y == 0) begin
                    walk_phase = PH_IDLE;
                end else begin
                    off_y = OFF_BITS'(y - 1);
                end
            end
            default: begin
                // nothing running, the step is dropped
            end
        endcase
    endtask

    task automatic check_field(
        input string                      name,
        input logic signed [OUT_BITS-1:0] want,
        input logic signed [OUT_BITS-1:0] got
    );
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_point_set want;
        if (!i_rst_n) begin
            grid_step  = GRID_BITS'(1);
            off_x      = '0;
            off_y      = '0;
            decision   = '0;
            walk_phase = PH_IDLE;
            ctr_x      = '0;
            ctr_y      = '0;
            axis_a     = '0;
            axis_b     = '0;
            expected_points.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                grid_step = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                walk_request(i_req.req_type, i_req.center_x, i_req.center_y,
                             i_req.semi_axis_x, i_req.semi_axis_y);
            end
            if (i_pix.valid && i_pix.ready) begin
                if (expected_points.size() == 0) begin
                    $error("point set with none expected: %0d %0d %0d %0d last %0b",
                           i_pix.x_right, i_pix.x_left, i_pix.y_upper, i_pix.y_lower,
                           i_pix.is_last);
                    o_fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("x_right", want.x_right, i_pix.x_right);
                    check_field("x_left", want.x_left, i_pix.x_left);
                    check_field("y_upper", want.y_upper, i_pix.y_upper);
                    check_field("y_lower", want.y_lower, i_pix.y_lower);
                    check_field("is_last", OUT_BITS'(want.is_last),
                                OUT_BITS'(i_pix.is_last));
                end
            end
        end
        o_pending = expected_points.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the ellipse rasterizer with directed and random ellipse walks
// under bursty requests and a stalling pixel sink; the checker beside the
// core predicts and compares every point set
// ----------------------------------------------------------------------------
module tb_top;
    import mer_pkg::*;

    // receiver behavior, picked afresh whenever the current mode runs out
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [GRID_BITS-1:0] cfg_wdata;

    int                   pending;
    int                   fail_count;
    // words left in the current request burst
    int                   burst_left;
    // asks the receiver for one long hold-off
    bit                   long_hold_req;

    mer_in_if  req_if ();
    mer_out_if pix_if ();

    midpoint_ellipse_rasterizer_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_pix       (pix_if)
    );

    mer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_if),
        .i_pix        (pix_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial begin
        #10_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // pixel sink: mixes always-ready stretches, random stalls and a fixed
    // pattern, plus one long hold-off on request so the core backs up
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        pix_if.ready <= 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 300;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                pix_if.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS:  pix_if.ready <= 1'b1;
                    RX_MOSTLY:  pix_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:  pix_if.ready <= ($urandom_range(0, 3) == 0);
                    default:    pix_if.ready <= ((mode_left % 5) < 2);
                endcase
            end
        end
    end

    // offer one request word and return at the edge that takes it; valid is
    // left high so the next word follows without a bubble unless a gap is due
    task automatic send_word(
        input logic                  kind,
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [AXIS_BITS-1:0]  sa,
        input logic [AXIS_BITS-1:0]  sb
    );
        int gap;
        bit taken;
        if (burst_left == 0) begin
            // mostly short bursts, now and then a long run with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 15);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.center_x    <= cx;
        req_if.center_y    <= cy;
        req_if.semi_axis_x <= sa;
        req_if.semi_axis_y <= sb;
        // ready is stable by the falling edge and holds until the next rise
        do begin
            @(negedge clk);
            taken = req_if.ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // start an ellipse and advance it a given number of pixels; the unused
    // fields of step words carry random junk
    task automatic walk_ellipse(
        input logic [COORD_BITS-1:0] cx,
        input logic [COORD_BITS-1:0] cy,
        input logic [AXIS_BITS-1:0]  sa,
        input logic [AXIS_BITS-1:0]  sb,
        input int                    steps
    );
        send_word(REQ_START, cx, cy, sa, sb);
        repeat (steps) begin
            send_word(REQ_STEP, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                      AXIS_BITS'($urandom()), AXIS_BITS'($urandom()));
        end
    endtask

    // stop offering, wait until every expected point set is out, then give
    // a dropped step time to finish inside the core
    task automatic settle();
        req_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_grid(input logic [GRID_BITS-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int phase_idx;
        int counted;
        int pick;
        int sa;
        int sb;
        int steps;
        logic [GRID_BITS-1:0] grid;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_START;
        req_if.center_x    <= '0;
        req_if.center_y    <= '0;
        req_if.semi_axis_x <= '0;
        req_if.semi_axis_y <= '0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part, grid step at its reset value of one ---
        // advance with no ellipse running: dropped, no point set
        send_word(REQ_STEP, '0, '0, '0, '0);
        // both axes zero: top point, then the bridge point ends it at once,
        // and the extra step falls on an idle walker
        walk_ellipse('0, '0, '0, '0, 2);
        // zero horizontal axis: no region 1, bridge at x offset one, then
        // region 2 with x clamped back to zero
        walk_ellipse('1, '1, '0, AXIS_BITS'(2), 4);
        // zero vertical axis: bridge point is the last one
        walk_ellipse(COORD_BITS'(700), COORD_BITS'(300), AXIS_BITS'(4), '0, 1);
        settle();

        // zero written to the grid register acts as one
        write_grid('0);
        walk_ellipse(COORD_BITS'(2000), COORD_BITS'(1500), AXIS_BITS'(3), AXIS_BITS'(2), 3);
        settle();
        // grid step changes with the ellipse half drawn
        write_grid(GRID_BITS'(5));
        repeat (5) send_word(REQ_STEP, '0, '1, '1, '0);
        settle();

        // largest grid and axes push the y coordinates of the first ellipse into
        // saturation; the second start cuts the first ellipse short
        write_grid('1);
        walk_ellipse('1, '0, '1, '1, 2);
        walk_ellipse('0, '1, '1, AXIS_BITS'(1), 2);
        settle();

        // --- random part, one grid setting per phase ---
        for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
            case (phase_idx)
                0:       grid = GRID_BITS'(64);
                1:       grid = GRID_BITS'(1);
                2:       grid = GRID_BITS'($urandom_range(2, 63));
                3:       grid = '0;
                4:       grid = '1;
                default: grid = GRID_BITS'($urandom_range(0, 127));
            endcase
            write_grid(grid);
            if (phase_idx == 1) begin
                // sink holds off while a long ellipse keeps the core busy,
                // so the output register fills and requests back up
                long_hold_req = 1'b1;
                walk_ellipse(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                             AXIS_BITS'(40), AXIS_BITS'(30), 72);
            end
            counted = 0;
            while (counted < 200) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // complete ellipse, mostly small, a few steps to spare
                    sa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                     : $urandom_range(0, 20);
                    sb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                     : $urandom_range(0, 20);
                    walk_ellipse(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                                 AXIS_BITS'(sa), AXIS_BITS'(sb),
                                 sa + sb + $urandom_range(2, 4));
                    counted += sa + sb + 3;
                end else if (pick < 90) begin
                    // full-range axes, abandoned after a few pixels
                    steps = $urandom_range(0, 6);
                    walk_ellipse(COORD_BITS'($urandom()), COORD_BITS'($urandom()),
                                 AXIS_BITS'($urandom()), AXIS_BITS'($urandom()), steps);
                    counted += steps + 1;
                end else begin
                    // stray steps, often onto an idle walker
                    repeat ($urandom_range(1, 3)) begin
                        send_word(REQ_STEP, COORD_BITS'($urandom()),
                                  COORD_BITS'($urandom()), AXIS_BITS'($urandom()),
                                  AXIS_BITS'($urandom()));
                    end
                end
            end
            settle();
        end

        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mer_pkg.sv
sv/mer_in_if.sv
sv/mer_out_if.sv
sv/mer_mul.sv
sv/midpoint_ellipse_rasterizer_core.sv
sim/mer_checker.sv
sim/tb_top.sv
